// File: design/vmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmp_pkg
// Shared types, codes and helpers for the two-channel level meter.
// ----------------------------------------------------------------------------
package vmp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 15;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int DECAY_SHIFT = 4;
  localparam int LIT_W       = 5;
  localparam int PEAK_W      = 4;

  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_PEAK    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DECAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HOLD   = 2'd1;

  localparam logic [CFG_W-1:0] LEVEL_DECAY_RST = 16'd50;
  localparam logic [CFG_W-1:0] PEAK_HOLD_RST   = 16'd2000;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       channel;
    logic [TIME_W-1:0]          now_ms;
  } item_t;

  typedef struct packed {
    logic              report_channel;
    logic [LIT_W-1:0]  lit_segments;
    logic [PEAK_W-1:0] peak_segment;
  } report_t;

  typedef struct packed {
    logic [CFG_W-1:0] level_decay_ms;
    logic [CFG_W-1:0] peak_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] held_peak;
  } meter_t;

  function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: design/vmp_chan_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmp_chan_state
// Per-channel level, held peak and timestamps with their update rules.
// ----------------------------------------------------------------------------
module vmp_chan_state (
  input  logic           clk,
  input  logic           rst,
  input  vmp_pkg::cfg_t  cfg,
  input  logic           go,
  input  vmp_pkg::item_t item,
  output vmp_pkg::meter_t view
);
  import vmp_pkg::*;

  logic [LEVEL_W-1:0] level      [2];
  logic [LEVEL_W-1:0] held_peak  [2];
  logic [TIME_W-1:0]  level_stamp[2];
  logic [TIME_W-1:0]  peak_stamp [2];

  logic [LEVEL_W-1:0] level_next      [2];
  logic [LEVEL_W-1:0] held_peak_next  [2];
  logic [TIME_W-1:0]  level_stamp_next[2];
  logic [TIME_W-1:0]  peak_stamp_next [2];

  logic [SAMPLE_W-1:0] smp      [2];
  logic                decay_hit[2];
  logic                hold_hit [2];
  logic [LEVEL_W-1:0]  decayed  [2];

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      level_next[ch]       = level[ch];
      held_peak_next[ch]   = held_peak[ch];
      level_stamp_next[ch] = level_stamp[ch];
      peak_stamp_next[ch]  = peak_stamp[ch];

      smp[ch]       = (ch == 0) ? item.left_sample : item.right_sample;
      decay_hit[ch] = abs_diff(item.now_ms, level_stamp[ch]) >
                      {{(TIME_W-CFG_W){1'b0}}, cfg.level_decay_ms};
      decayed[ch]   = decay_hit[ch] ? (level[ch] - (level[ch] >> DECAY_SHIFT))
                                    : level[ch];
      hold_hit[ch]  = abs_diff(item.now_ms, peak_stamp[ch]) >
                      {{(TIME_W-CFG_W){1'b0}}, cfg.peak_hold_ms};

      if (go) begin
        case (item.op)
          OP_SAMPLE: begin
            if (!smp[ch][SAMPLE_W-1] && (smp[ch][LEVEL_W-1:0] > level[ch])) begin
              level_next[ch] = smp[ch][LEVEL_W-1:0];
            end
          end
          OP_PEAK: begin
            if ((item.channel == 1'(ch)) && (level[ch] > held_peak[ch])) begin
              held_peak_next[ch] = level[ch];
            end
          end
          OP_REFRESH: begin
            if (item.channel == 1'(ch)) begin
              if (decay_hit[ch]) begin
                level_next[ch]       = decayed[ch];
                level_stamp_next[ch] = item.now_ms;
              end
              // peak falls to the level after this refresh's decay
              if (hold_hit[ch]) begin
                held_peak_next[ch]  = decayed[ch];
                peak_stamp_next[ch] = item.now_ms;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 2; ch++) begin
      if (rst) begin
        level[ch]       <= '0;
        held_peak[ch]   <= '0;
        level_stamp[ch] <= '0;
        peak_stamp[ch]  <= '0;
      end else begin
        level[ch]       <= level_next[ch];
        held_peak[ch]   <= held_peak_next[ch];
        level_stamp[ch] <= level_stamp_next[ch];
        peak_stamp[ch]  <= peak_stamp_next[ch];
      end
    end
  end

  assign view.level     = item.channel ? level[1] : level[0];
  assign view.held_peak = item.channel ? held_peak[1] : held_peak[0];

endmodule

// File: design/vmp_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmp_scale
// Converts level and held peak into bar segment counts by threshold compare.
// ----------------------------------------------------------------------------
module vmp_scale #(
  parameter int SEGMENTS   = 16,
  parameter int FULL_SCALE = 32767
) (
  input  vmp_pkg::meter_t          view,
  output logic [vmp_pkg::LIT_W-1:0]  lit,
  output logic [vmp_pkg::PEAK_W-1:0] pk
);
  import vmp_pkg::*;

  localparam int DIV_RAW = FULL_SCALE / SEGMENTS;
  localparam int DIV     = (DIV_RAW == 0) ? 1 : DIV_RAW;
  localparam int CNT_W   = $clog2(SEGMENTS + 1);

  logic [CNT_W-1:0] lit_cnt;
  logic [CNT_W-1:0] pk_cnt;

  // thresholds k*DIV rise with k, so the last one passed is the quotient
  always_comb begin
    lit_cnt = '0;
    pk_cnt  = '0;
    for (int k = 1; k <= SEGMENTS; k++) begin
      if ({{(32-LEVEL_W){1'b0}}, view.level} >= 32'(k * DIV)) begin
        lit_cnt = CNT_W'(k);
      end
      if ((k < SEGMENTS) &&
          ({{(32-LEVEL_W){1'b0}}, view.held_peak} >= 32'(k * DIV))) begin
        pk_cnt = CNT_W'(k);
      end
    end
  end

  assign lit = LIT_W'(lit_cnt);
  assign pk  = PEAK_W'(pk_cnt);

endmodule

// File: design/vu_meter_peak_hold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vu_meter_peak_hold
// Two-channel audio level meter with peak hold and bar segment report.
// ----------------------------------------------------------------------------
// One beat per cycle is taken on the item channel while it is not stalled. A
// beat is held in the input register, where the channel state is read and
// updated, and a refresh beat then passes on to the report register, from
// which its report goes out. The item channel stalls only while a refresh
// sits in the input register and the report register is full and stalled.
module vu_meter_peak_hold #(
  parameter int SEGMENTS   = 16,
  parameter int FULL_SCALE = 32767
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vmp_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  vmp_pkg::item_t                    item,
  output logic                              report_valid,
  input  logic                              report_stall,
  output vmp_pkg::report_t                  report
);
  import vmp_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  item_t   s1_item;
  logic    s1_go;
  logic    s1_refresh;
  meter_t  view;
  logic [LIT_W-1:0]  lit;
  logic [PEAK_W-1:0] pk;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_decay_ms <= LEVEL_DECAY_RST;
      cfg.peak_hold_ms   <= PEAK_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_DECAY: cfg.level_decay_ms <= cfg_data;
        REG_PEAK_HOLD:   cfg.peak_hold_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s1_refresh = (s1_item.op == OP_REFRESH);
  assign s1_go      = s1_valid && (!s1_refresh || !report_valid || !report_stall);
  assign item_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  vmp_chan_state u_state (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .go   (s1_go),
    .item (s1_item),
    .view (view)
  );

  vmp_scale #(
    .SEGMENTS   (SEGMENTS),
    .FULL_SCALE (FULL_SCALE)
  ) u_scale (
    .view (view),
    .lit  (lit),
    .pk   (pk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (s1_go && s1_refresh) begin
      report_valid <= 1'b1;
    end else if (!report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_refresh) begin
      report.report_channel <= s1_item.channel;
      report.lit_segments   <= lit;
      report.peak_segment   <= pk;
    end
  end

  a_refresh_reports: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_refresh) |=>
      (report_valid && (report.report_channel == $past(s1_item.channel))))
    else $error("refresh beat did not produce its report");

  a_stall_needs_refresh: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && s1_refresh && report_valid && report_stall))
    else $error("item channel stalled without a blocked refresh");

  a_peak_clamped: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_refresh) |=> (32'(report.peak_segment) <= 32'(SEGMENTS - 1)))
    else $error("peak segment beyond last segment");

endmodule

// File: dv/vu_meter_peak_hold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vu_meter_peak_hold_tb
// Self-checking bench for the two-channel level meter. A queue-fed driver
// sends sample, peak, refresh and unused-op beats in random bursts. A clocked
// monitor keeps its own copy of the meter state, works out every report at
// input acceptance and compares each output beat in order. Register writes
// happen only while the meter is drained, and the receiver stalls on its own
// pattern, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module vu_meter_peak_hold_tb;
  import vmp_pkg::*;

  localparam int SEGMENTS   = 16;
  localparam int FULL_SCALE = 32767;
  localparam int SEG_STEP   = (FULL_SCALE / SEGMENTS == 0) ? 1 : FULL_SCALE / SEGMENTS;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int PHASE_BEATS = 85;
  localparam int LONG_HOLD   = 300;
  localparam int WATCHDOG    = 4000;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              item_valid = 1'b0;
  logic              item_stall;
  item_t             item = '0;
  logic              report_valid;
  logic              report_stall = 1'b0;
  report_t           report;

  vu_meter_peak_hold #(
    .SEGMENTS  (SEGMENTS),
    .FULL_SCALE(FULL_SCALE)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .report_valid(report_valid),
    .report_stall(report_stall),
    .report      (report)
  );

  // meter state as the bench sees it
  logic [LEVEL_W-1:0] lvl [2];
  logic [LEVEL_W-1:0] peak [2];
  logic [TIME_W-1:0]  lvl_stamp [2];
  logic [TIME_W-1:0]  peak_stamp [2];
  logic [CFG_W-1:0]   decay_ms;
  logic [CFG_W-1:0]   hold_ms;

  item_t   beats_to_send [$];
  report_t reports_due [$];

  int  beats_queued, beats_in, reports_seen, errors;
  int  cfg_writes, long_holds, input_stall_cycles, idle_cycles;
  bit  hold_req;
  int  hold_left, mode_left, stall_pct;
  int  burst_left, gap_left;
  logic [TIME_W-1:0] wall_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                 input logic [TIME_W-1:0] stamp);
    return (now > stamp) ? now - stamp : stamp - now;
  endfunction

  function automatic void meter_clear();
    for (int c = 0; c < 2; c++) begin
      lvl[c] = '0;
      peak[c] = '0;
      lvl_stamp[c] = '0;
      peak_stamp[c] = '0;
    end
    decay_ms = LEVEL_DECAY_RST;
    hold_ms  = PEAK_HOLD_RST;
  endfunction

  function automatic void meter_take(input int c, input logic [SAMPLE_W-1:0] s);
    if (!s[SAMPLE_W-1] && s[LEVEL_W-1:0] > lvl[c]) lvl[c] = s[LEVEL_W-1:0];
  endfunction

  function automatic void meter_step(input item_t b);
    int      c;
    int      lit, pk;
    report_t r;
    c = b.channel;
    case (b.op)
      OP_SAMPLE: begin
        meter_take(0, b.left_sample);
        meter_take(1, b.right_sample);
      end
      OP_PEAK: begin
        if (lvl[c] > peak[c]) peak[c] = lvl[c];
      end
      OP_REFRESH: begin
        lit = int'(lvl[c]) / SEG_STEP;
        if (lit > SEGMENTS) lit = SEGMENTS;
        pk = int'(peak[c]) / SEG_STEP;
        if (pk >= SEGMENTS) pk = SEGMENTS - 1;
        r.report_channel = b.channel;
        r.lit_segments   = lit[LIT_W-1:0];
        r.peak_segment   = pk[PEAK_W-1:0];
        reports_due.push_back(r);
        if (elapsed(b.now_ms, lvl_stamp[c]) > {16'd0, decay_ms}) begin
          lvl[c] = lvl[c] - (lvl[c] >> DECAY_SHIFT);
          lvl_stamp[c] = b.now_ms;
        end
        if (elapsed(b.now_ms, peak_stamp[c]) > {16'd0, hold_ms}) begin
          peak[c] = lvl[c];
          peak_stamp[c] = b.now_ms;
        end
      end
      default: ;
    endcase
  endfunction

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      meter_clear();
      reports_due.delete();
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_we) begin
        idle_cycles = 0;
        if (cfg_index == REG_LEVEL_DECAY) decay_ms = cfg_data;
        else if (cfg_index == REG_PEAK_HOLD) hold_ms = cfg_data;
      end
      if (item_valid && item_stall) input_stall_cycles++;
      if (item_valid && !item_stall) begin
        idle_cycles = 0;
        beats_in++;
        meter_step(item);
      end
      if (report_valid && !report_stall) begin
        report_t want;
        idle_cycles = 0;
        reports_seen++;
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected report beat, actual %p", $time, report);
        end else begin
          want = reports_due.pop_front();
          if (report.report_channel !== want.report_channel) begin
            errors++;
            $display("%0t: report_channel expected %0d actual %0d", $time,
                     want.report_channel, report.report_channel);
          end
          if (report.lit_segments !== want.lit_segments) begin
            errors++;
            $display("%0t: lit_segments expected %0d actual %0d", $time,
                     want.lit_segments, report.lit_segments);
          end
          if (report.peak_segment !== want.peak_segment) begin
            errors++;
            $display("%0t: peak_segment expected %0d actual %0d", $time,
                     want.peak_segment, report.peak_segment);
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!item_valid || !item_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (beats_to_send.size() > 0) begin
        item <= beats_to_send.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: stall rate picked anew for each random-length mode, plus long hold-off
  always @(posedge clk) begin
    if (rst) begin
      report_stall <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      stall_pct = 0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 80);
        stall_pct = 30 * $urandom_range(0, 3);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        report_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
        long_holds++;
        report_stall <= 1'b1;
      end else begin
        report_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic item_t make_beat(input logic [1:0] op, input logic [SAMPLE_W-1:0] l,
                                      input logic [SAMPLE_W-1:0] r, input logic ch,
                                      input logic [TIME_W-1:0] now);
    item_t b;
    b.op = op;
    b.left_sample = l;
    b.right_sample = r;
    b.channel = ch;
    b.now_ms = now;
    return b;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return SAMPLE_W'($urandom);
    if (sel < 60) return SAMPLE_W'($urandom_range(0, 32767));
    if (sel < 85) return SAMPLE_W'($urandom_range(0, 32767) >> $urandom_range(1, 10));
    return SAMPLE_W'(32'd0 - $urandom_range(1, 32768));
  endfunction

  task automatic queue_beat(input item_t b);
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  task automatic advance_ms();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) wall_ms += $urandom_range(0, 120);
    else if (sel < 75) wall_ms += $urandom_range(0, 3000);
    else if (sel < 90) wall_ms += $urandom_range(0, 140000);
    else if (sel < 95) wall_ms -= $urandom_range(0, 5000);
    else wall_ms = $urandom;
  endtask

  // one frame: a run of sample pairs, maybe a peak update, then refreshes;
  // now and then a short run of noise instead
  task automatic queue_frame();
    int  n;
    bit  first;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 4);
      repeat (n)
        queue_beat(make_beat(2'($urandom_range(0, 3)), rand_sample(), rand_sample(),
                             1'($urandom), $urandom));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n)
        queue_beat(make_beat(OP_SAMPLE, rand_sample(), rand_sample(), 1'($urandom),
                             $urandom));
      if ($urandom_range(0, 1))
        queue_beat(make_beat(OP_PEAK, rand_sample(), rand_sample(), 1'($urandom),
                             $urandom));
      advance_ms();
      first = 1'($urandom);
      queue_beat(make_beat(OP_REFRESH, rand_sample(), rand_sample(), first, wall_ms));
      if ($urandom_range(0, 3) != 0)
        queue_beat(make_beat(OP_REFRESH, rand_sample(), rand_sample(), !first, wall_ms));
    end
  endtask

  task automatic drain();
    while (beats_in != beats_queued || reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [CFG_W-1:0] decay_set [7];
    logic [CFG_W-1:0] hold_set [7];
    int               target;

    decay_set = '{16'd0, 16'd65535, 16'd50, 16'd1, 16'd65535, 16'd0, 16'd0};
    hold_set  = '{16'd0, 16'd65535, 16'd2000, 16'd65535, 16'd0, 16'd0, 16'd0};
    decay_set[5] = 16'($urandom_range(0, 65535));
    hold_set[5]  = 16'($urandom_range(0, 65535));
    decay_set[6] = 16'($urandom_range(0, 300));
    hold_set[6]  = 16'($urandom_range(0, 5000));
    wall_ms = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_SAMPLE, 16'h7FFF, 16'h8000, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_PEAK, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_REFRESH, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_SAMPLE, 16'hFFFF, 16'h0001, 1'b1, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_SAMPLE, 16'h0000, 16'h7FFF, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_UNUSED, 16'h7FFF, 16'h7FFF, 1'b1, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_UNUSED, 16'h8000, 16'h8000, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_PEAK, 16'h0000, 16'h0000, 1'b1, 32'h0000_0000));
    // decay boundary: strictly more than the interval
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b1, 32'd51));
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b1, 32'd101));
    // hold boundary
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b1, 32'd2000));
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b1, 32'd2001));
    queue_beat(make_beat(OP_SAMPLE, 16'h5555, 16'hAAAA, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_SAMPLE, 16'h2AAA, 16'h5555, 1'b1, 32'h0000_0000));
    queue_beat(make_beat(OP_PEAK, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000));
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b0, 32'h5555_5555));
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b1, 32'hAAAA_AAAA));
    queue_beat(make_beat(OP_REFRESH, 16'h0000, 16'h0000, 1'b0, 32'h5555_5555));
    wall_ms = 32'hAAAA_AAAA;
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_LEVEL_DECAY, decay_set[ph]);
      write_reg(REG_PEAK_HOLD, hold_set[ph]);
      if (ph == 2) begin
        write_reg(REG_SPARE_2, 16'($urandom));
        write_reg(REG_SPARE_3, 16'($urandom));
      end
      if (ph == 3) begin
        // reports back up while refreshes keep coming
        hold_req = 1'b1;
        repeat (30) begin
          advance_ms();
          queue_beat(make_beat(OP_REFRESH, rand_sample(), rand_sample(), 1'($urandom),
                               wall_ms));
        end
      end
      target = beats_queued + PHASE_BEATS;
      while (beats_queued < target) queue_frame();
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d beats, checked %0d reports over %0d register writes.",
             beats_in, reports_seen, cfg_writes);
    $display("Long report hold-offs: %0d, input stall cycles: %0d.",
             long_holds, input_stall_cycles);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", errors, reports_due.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
design/vmp_pkg.sv
design/vmp_chan_state.sv
design/vmp_scale.sv
design/vu_meter_peak_hold.sv
dv/vu_meter_peak_hold_tb.sv
